// ===== hw/rtl/dda_pkg.sv =====
// Shared types and constants of the DDA line rasterizer.
package dda_pkg;

   localparam int COORD_BITS  = 11;
   localparam int FRAC_BITS   = 16;
   localparam int POS_BITS    = COORD_BITS + FRAC_BITS;
   localparam int STEP_BITS   = FRAC_BITS + 2;
   localparam int QUEUE_DEPTH = 4;

   localparam logic REQ_START = 1'b0;
   localparam logic REQ_NEXT  = 1'b1;

   typedef logic [COORD_BITS-1:0] coord_type;
   typedef logic [STEP_BITS-1:0]  step_type;
   typedef logic [POS_BITS-1:0]   pos_type;

   typedef struct packed {
      logic      req_type;
      coord_type start_x;
      coord_type start_y;
      coord_type end_x;
      coord_type end_y;
   } req_item_type;

   typedef struct packed {
      logic      pixel_valid;
      coord_type pixel_x;
      coord_type pixel_y;
      logic      last_pixel;
   } rsp_item_type;

   typedef struct packed {
      logic      is_start;
      logic      line_nonzero;
      coord_type start_x;
      coord_type start_y;
      coord_type end_x;
      coord_type end_y;
      step_type  step_x;
      step_type  step_y;
   } cmd_item_type;

endpackage

// ===== hw/rtl/dda_front.sv =====
// Request front end: accepts requests and works out the line steps by division.
module dda_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   output logic                  req_full,
   input  dda_pkg::req_item_type req_data,
   output logic                  cmd_push,
   output dda_pkg::cmd_item_type cmd_data,
   input  logic                  cmd_full
);

   localparam int C        = dda_pkg::COORD_BITS;
   localparam int F        = dda_pkg::FRAC_BITS;
   localparam int CNT_BITS = $clog2(F + 2);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_DIVIDE = 3'b010,
      ST_PUSH   = 3'b100
   } state_type;

   state_type state_ff, state_in;
   dda_pkg::req_item_type op_ff, op_in;
   logic neg_x_ff, neg_x_in, neg_y_ff, neg_y_in;
   logic zero_ff, zero_in;
   logic [C:0] rem_x_ff, rem_x_in, rem_y_ff, rem_y_in;
   logic [C-1:0] divisor_ff, divisor_in;
   logic [F:0] quot_x_ff, quot_x_in, quot_y_ff, quot_y_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;

   logic accept;
   logic [C:0] dx, dy, neg_dx, neg_dy;
   logic [C-1:0] mag_x, mag_y, max_d;
   logic bit_x, bit_y;
   logic [C:0] rem_x_after, rem_y_after;
   logic [F+1:0] qext_x, qext_y;

   assign req_full = (state_ff != ST_IDLE) || cmd_full;
   assign accept   = req_push && !req_full;

   always_comb begin
      dx     = {1'b0, req_data.end_x} - {1'b0, req_data.start_x};
      dy     = {1'b0, req_data.end_y} - {1'b0, req_data.start_y};
      neg_dx = (C+1)'(0) - dx;
      neg_dy = (C+1)'(0) - dy;
      mag_x  = dx[C] ? neg_dx[C-1:0] : dx[C-1:0];
      mag_y  = dy[C] ? neg_dy[C-1:0] : dy[C-1:0];
      max_d  = (mag_x > mag_y) ? mag_x : mag_y;
   end

   // One quotient bit per cycle; after each subtraction the remainder is below the divisor.
   always_comb begin
      bit_x       = rem_x_ff >= {1'b0, divisor_ff};
      bit_y       = rem_y_ff >= {1'b0, divisor_ff};
      rem_x_after = bit_x ? (rem_x_ff - {1'b0, divisor_ff}) : rem_x_ff;
      rem_y_after = bit_y ? (rem_y_ff - {1'b0, divisor_ff}) : rem_y_ff;
      qext_x      = {1'b0, quot_x_ff};
      qext_y      = {1'b0, quot_y_ff};
   end

   always_comb begin
      state_in   = state_ff;
      op_in      = op_ff;
      neg_x_in   = neg_x_ff;
      neg_y_in   = neg_y_ff;
      zero_in    = zero_ff;
      rem_x_in   = rem_x_ff;
      rem_y_in   = rem_y_ff;
      divisor_in = divisor_ff;
      quot_x_in  = quot_x_ff;
      quot_y_in  = quot_y_ff;
      cnt_in     = cnt_ff;
      cmd_push   = 1'b0;
      cmd_data   = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_data.req_type == dda_pkg::REQ_NEXT) begin
                  cmd_push = 1'b1;
               end else begin
                  op_in      = req_data;
                  neg_x_in   = dx[C];
                  neg_y_in   = dy[C];
                  zero_in    = (max_d == '0);
                  rem_x_in   = {1'b0, mag_x};
                  rem_y_in   = {1'b0, mag_y};
                  divisor_in = max_d;
                  quot_x_in  = '0;
                  quot_y_in  = '0;
                  cnt_in     = '0;
                  state_in   = (max_d == '0) ? ST_PUSH : ST_DIVIDE;
               end
            end
         end
         ST_DIVIDE: begin
            rem_x_in  = {rem_x_after[C-1:0], 1'b0};
            rem_y_in  = {rem_y_after[C-1:0], 1'b0};
            quot_x_in = {quot_x_ff[F-1:0], bit_x};
            quot_y_in = {quot_y_ff[F-1:0], bit_y};
            cnt_in    = cnt_ff + 1'b1;
            if (cnt_ff == CNT_BITS'(F)) begin
               state_in = ST_PUSH;
            end
         end
         ST_PUSH: begin
            cmd_push              = !cmd_full;
            cmd_data.is_start     = 1'b1;
            cmd_data.line_nonzero = !zero_ff;
            cmd_data.start_x      = op_ff.start_x;
            cmd_data.start_y      = op_ff.start_y;
            cmd_data.end_x        = op_ff.end_x;
            cmd_data.end_y        = op_ff.end_y;
            cmd_data.step_x       = neg_x_ff ? ((F+2)'(0) - qext_x) : qext_x;
            cmd_data.step_y       = neg_y_ff ? ((F+2)'(0) - qext_y) : qext_y;
            if (!cmd_full) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      neg_x_ff   <= neg_x_in;
      neg_y_ff   <= neg_y_in;
      zero_ff    <= zero_in;
      rem_x_ff   <= rem_x_in;
      rem_y_ff   <= rem_y_in;
      divisor_ff <= divisor_in;
      quot_x_ff  <= quot_x_in;
      quot_y_ff  <= quot_y_in;
      cnt_ff     <= cnt_in;
   end

`ifndef SYNTH
   a_busy_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> req_full)
      else $error("front accepts a request while dividing");

   a_divide_ends_in_push: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVIDE && cnt_ff == CNT_BITS'(F)) |=> (state_ff == ST_PUSH))
      else $error("divider did not hand over after its last bit");
`endif

endmodule

// ===== hw/rtl/dda_queue.sv =====
// Short command queue between the front end and the stepping engine.
module dda_queue #(
   parameter int DEPTH = dda_pkg::QUEUE_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  dda_pkg::cmd_item_type wr_data,
   output logic                  full,
   input  logic                  pop,
   output dda_pkg::cmd_item_type rd_data,
   output logic                  empty
);

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   dda_pkg::cmd_item_type entry_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic do_push, do_pop;

   assign full    = (count_ff == CNT_BITS'(DEPTH));
   assign empty   = (count_ff == '0);
   assign rd_data = entry_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= wr_data;
      end
   end

`ifndef SYNTH
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full))
      else $error("command pushed into a full queue");

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_BITS'(DEPTH))
      else $error("queue count beyond its depth");
`endif

endmodule

// ===== hw/rtl/dda_back.sv =====
// Stepping engine: holds the line state and produces one result per command.
module dda_back (
   input  logic                  clock,
   input  logic                  reset,
   input  dda_pkg::cmd_item_type cmd_data,
   input  logic                  cmd_empty,
   output logic                  cmd_pop,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output dda_pkg::rsp_item_type rsp_data
);

   localparam int F = dda_pkg::FRAC_BITS;
   localparam int P = dda_pkg::POS_BITS;
   localparam int S = dda_pkg::STEP_BITS;

   dda_pkg::pos_type pos_x_ff, pos_x_in, pos_y_ff, pos_y_in;
   dda_pkg::step_type step_x_ff, step_x_in, step_y_ff, step_y_in;
   dda_pkg::coord_type target_x_ff, target_x_in, target_y_ff, target_y_in;
   logic active_ff, active_in;
   logic rsp_valid_ff, rsp_valid_in;
   dda_pkg::rsp_item_type rsp_ff, rsp_in;

   dda_pkg::pos_type sum_x, sum_y;
   logic [P:0] diff_x, diff_y;
   logic near_x, near_y;

   assign cmd_pop   = !cmd_empty && (!rsp_valid_ff || rsp_pop);
   assign rsp_empty = !rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // A difference lies strictly within one whole unit when its integer part is
   // zero, or all ones with a nonzero fraction.
   always_comb begin
      sum_x  = pos_x_ff + {{(P-S){step_x_ff[S-1]}}, step_x_ff};
      sum_y  = pos_y_ff + {{(P-S){step_y_ff[S-1]}}, step_y_ff};
      diff_x = {1'b0, sum_x} - {1'b0, target_x_ff, F'(0)};
      diff_y = {1'b0, sum_y} - {1'b0, target_y_ff, F'(0)};
      near_x = (diff_x[P:F] == '0) || ((&diff_x[P:F]) && (|diff_x[F-1:0]));
      near_y = (diff_y[P:F] == '0) || ((&diff_y[P:F]) && (|diff_y[F-1:0]));
   end

   always_comb begin
      pos_x_in     = pos_x_ff;
      pos_y_in     = pos_y_ff;
      step_x_in    = step_x_ff;
      step_y_in    = step_y_ff;
      target_x_in  = target_x_ff;
      target_y_in  = target_y_ff;
      active_in    = active_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_pop;
      if (cmd_pop) begin
         rsp_valid_in = 1'b1;
         rsp_in       = '0;
         if (cmd_data.is_start) begin
            pos_x_in    = {cmd_data.start_x, F'(0)};
            pos_y_in    = {cmd_data.start_y, F'(0)};
            step_x_in   = cmd_data.step_x;
            step_y_in   = cmd_data.step_y;
            target_x_in = cmd_data.end_x;
            target_y_in = cmd_data.end_y;
            active_in   = cmd_data.line_nonzero;
         end else if (active_ff) begin
            rsp_in.pixel_valid = 1'b1;
            rsp_in.pixel_x     = pos_x_ff[P-1:F];
            rsp_in.pixel_y     = pos_y_ff[P-1:F];
            rsp_in.last_pixel  = near_x && near_y;
            pos_x_in           = sum_x;
            pos_y_in           = sum_y;
            if (near_x && near_y) begin
               active_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_x_ff    <= pos_x_in;
      pos_y_ff    <= pos_y_in;
      step_x_ff   <= step_x_in;
      step_y_ff   <= step_y_in;
      target_x_ff <= target_x_in;
      target_y_ff <= target_y_in;
      rsp_ff      <= rsp_in;
   end

`ifndef SYNTH
   a_result_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_pop) |=> (rsp_valid_ff && $stable(rsp_ff)))
      else $error("waiting result lost or changed");

   a_last_ends_line: assert property (@(posedge clock) disable iff (reset)
      (cmd_pop && !cmd_data.is_start && active_ff && near_x && near_y) |=> !active_ff)
      else $error("line still active after its final pixel");
`endif

endmodule

// ===== hw/rtl/dda_line_rasterizer.sv =====
// Top level of the DDA line rasterizer.
// A start request (req_type 0) loads two endpoints and returns an all-zero result;
// each following next request (req_type 1) returns one pixel of the line, with
// last_pixel set on the final one, and all-zero results once the line is done or
// was of zero length. The end point itself is not drawn. Next requests are taken
// one per clock while the front end is idle and the command queue has room; each
// result passes through the command queue and the result register. A start occupies
// the front end through load, quotient bits of the restoring divider and hand-over to
// the command queue (load and hand-over only for a zero-length line); requests behind
// it wait. The command queue of QUEUE_DEPTH entries lets the divider and the pixel
// stepper stall independently, and a result register parts the stepper from the output.
module dda_line_rasterizer #(
   parameter int QUEUE_DEPTH = dda_pkg::QUEUE_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   output logic                  req_full,
   input  dda_pkg::req_item_type req_data,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output dda_pkg::rsp_item_type rsp_data
);

   dda_pkg::cmd_item_type cmd_wr_data, cmd_rd_data;
   logic cmd_push, cmd_full, cmd_pop, cmd_empty;

   dda_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_full (req_full),
      .req_data (req_data),
      .cmd_push (cmd_push),
      .cmd_data (cmd_wr_data),
      .cmd_full (cmd_full)
   );

   dda_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (cmd_push),
      .wr_data (cmd_wr_data),
      .full    (cmd_full),
      .pop     (cmd_pop),
      .rd_data (cmd_rd_data),
      .empty   (cmd_empty)
   );

   dda_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_data  (cmd_rd_data),
      .cmd_empty (cmd_empty),
      .cmd_pop   (cmd_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== tb/sv/tb_dda_line_rasterizer.sv =====
// Self-checking testbench for the DDA line rasterizer: directed table, then random line sequences.
`timescale 1ns / 1ps

module tb_dda_line_rasterizer;
   import dda_pkg::*;

   localparam int RANDOM_ITEMS    = 1200;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int STALL_LIMIT     = 4000;
   localparam int DRAIN_CYCLES    = 40;
   localparam int REPORT_LIMIT    = 10;
   localparam int COORD_MAX       = (1 << COORD_BITS) - 1;

   typedef struct packed {
      req_item_type request;
      logic         typed;
      rsp_item_type pixel;
   } directed_row_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_push = 1'b0;
   logic         req_full;
   req_item_type req_data = '0;
   logic         rsp_empty;
   logic         rsp_pop = 1'b0;
   rsp_item_type rsp_data;

   // Predicted state of the rasterizer.
   pos_type   pos_x_q, pos_y_q;
   step_type  step_x_q, step_y_q;
   coord_type target_x_q, target_y_q;
   logic      line_busy;

   rsp_item_type     pending_pixels[$];
   directed_row_type directed_rows[$];

   int  failure_count = 0;
   int  results_checked = 0;
   int  line_ends = 0;
   int  lines_started = 0;
   int  pixel_requests = 0;
   int  drawing_requests = 0;
   int  quiet_cycles = 0;
   bit  hold_off_request = 1'b0;
   bit  steady_stretch = 1'b0;

   dda_line_rasterizer dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic int magnitude(int value);
      return (value < 0) ? -value : value;
   endfunction

   function automatic coord_type clamp_coord(int value);
      if (value < 0) return '0;
      if (value > COORD_MAX) return coord_type'(COORD_MAX);
      return coord_type'(value);
   endfunction

   // Signed step: delta / span in fixed point, truncated toward zero.
   function automatic step_type divide_step(int delta, int span);
      longint quotient;
      quotient = (longint'(magnitude(delta)) << FRAC_BITS) / longint'(span);
      if (delta < 0) quotient = -quotient;
      return step_type'(quotient);
   endfunction

   function automatic pos_type advance_position(pos_type pos, step_type step);
      return pos_type'(longint'(pos) + longint'(signed'(step)));
   endfunction

   function automatic bit close_to_target(pos_type pos, coord_type target);
      longint gap;
      gap = longint'(pos) - (longint'(target) << FRAC_BITS);
      return (gap > -(longint'(1) << FRAC_BITS)) && (gap < (longint'(1) << FRAC_BITS));
   endfunction

   function automatic rsp_item_type rasterize_request(req_item_type request);
      rsp_item_type pixel;
      int dx, dy, span;
      pixel = '0;
      if (request.req_type == REQ_START) begin
         dx = int'(request.end_x) - int'(request.start_x);
         dy = int'(request.end_y) - int'(request.start_y);
         span = (magnitude(dx) > magnitude(dy)) ? magnitude(dx) : magnitude(dy);
         pos_x_q = {request.start_x, {FRAC_BITS{1'b0}}};
         pos_y_q = {request.start_y, {FRAC_BITS{1'b0}}};
         target_x_q = request.end_x;
         target_y_q = request.end_y;
         line_busy = (span != 0);
         step_x_q = line_busy ? divide_step(dx, span) : '0;
         step_y_q = line_busy ? divide_step(dy, span) : '0;
      end else if (line_busy) begin
         pixel.pixel_valid = 1'b1;
         pixel.pixel_x = pos_x_q[POS_BITS-1:FRAC_BITS];
         pixel.pixel_y = pos_y_q[POS_BITS-1:FRAC_BITS];
         pos_x_q = advance_position(pos_x_q, step_x_q);
         pos_y_q = advance_position(pos_y_q, step_y_q);
         if (close_to_target(pos_x_q, target_x_q) && close_to_target(pos_y_q, target_y_q)) begin
            line_busy = 1'b0;
            pixel.last_pixel = 1'b1;
         end
      end
      return pixel;
   endfunction

   function automatic req_item_type random_request(logic kind);
      req_item_type request;
      request.req_type = kind;
      request.start_x = coord_type'($urandom);
      request.start_y = coord_type'($urandom);
      request.end_x = coord_type'($urandom);
      request.end_y = coord_type'($urandom);
      return request;
   endfunction

   function automatic directed_row_type table_row(logic kind, int sx, int sy, int ex, int ey,
                                                  int typed, int valid, int px, int py,
                                                  int last);
      directed_row_type row;
      row.request.req_type = kind;
      row.request.start_x = coord_type'(sx);
      row.request.start_y = coord_type'(sy);
      row.request.end_x = coord_type'(ex);
      row.request.end_y = coord_type'(ey);
      row.typed = (typed != 0);
      row.pixel.pixel_valid = (valid != 0);
      row.pixel.pixel_x = coord_type'(px);
      row.pixel.pixel_y = coord_type'(py);
      row.pixel.last_pixel = (last != 0);
      return row;
   endfunction

   task automatic report_failure(string what);
      failure_count++;
      if (failure_count <= REPORT_LIMIT) $display("ERROR at %0t: %s", $realtime, what);
   endtask

   // Offers one request and waits for its transfer; the expectation is queued on acceptance.
   task automatic send_request(req_item_type request, bit typed, rsp_item_type typed_pixel);
      rsp_item_type predicted;
      if (!steady_stretch && $urandom_range(99) < 11) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_data <= request;
      do @(posedge clock); while (req_full);
      if (request.req_type == REQ_START) begin
         lines_started++;
         drawing_requests++;
      end else if (line_busy) begin
         pixel_requests++;
         drawing_requests++;
      end
      predicted = rasterize_request(request);
      pending_pixels.push_back(typed ? typed_pixel : predicted);
   endtask

   task automatic wait_for_drain();
      while (pending_pixels.size() != 0) @(posedge clock);
   endtask

   // One start followed by a run of next requests; now and then a lone random request.
   task automatic run_line_sequence();
      req_item_type request;
      int sx, sy, ex, ey, span, pixel_count, mode;
      mode = $urandom_range(99);
      if (mode < 10) begin
         send_request(random_request(logic'($urandom_range(1))), 1'b0, '0);
         return;
      end
      request = random_request(REQ_START);
      sx = int'(request.start_x);
      sy = int'(request.start_y);
      if (mode < 65) begin
         ex = sx + int'($urandom_range(24)) - 12;
         ey = sy + int'($urandom_range(24)) - 12;
      end else if (mode < 88) begin
         ex = sx + int'($urandom_range(400)) - 200;
         ey = sy + int'($urandom_range(400)) - 200;
      end else begin
         ex = int'(request.end_x);
         ey = int'(request.end_y);
      end
      request.end_x = clamp_coord(ex);
      request.end_y = clamp_coord(ey);
      span = magnitude(int'(request.end_x) - sx);
      if (magnitude(int'(request.end_y) - sy) > span) span = magnitude(int'(request.end_y) - sy);
      send_request(request, 1'b0, '0);
      // Most lines run to their end; long ones and a few others are cut short by the next start.
      pixel_count = span + int'($urandom_range(2));
      if (span > 250 || $urandom_range(99) < 15) begin
         pixel_count = int'($urandom_range((span < 40) ? span : 40));
      end
      repeat (pixel_count) send_request(random_request(REQ_NEXT), 1'b0, '0);
   endtask

   initial begin : receiver
      int held;
      forever begin
         @(posedge clock);
         if (hold_off_request) begin
            rsp_pop <= 1'b0;
            for (held = 0; held < HOLD_OFF_CYCLES; held++) @(posedge clock);
            hold_off_request = 1'b0;
         end
         rsp_pop <= steady_stretch || ($urandom_range(99) >= 11);
      end
   end

   always @(posedge clock) begin
      rsp_item_type wanted;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (pending_pixels.size() == 0) begin
            report_failure($sformatf("result with nothing expected: valid=%0b x=%0d y=%0d last=%0b",
                                     rsp_data.pixel_valid, rsp_data.pixel_x, rsp_data.pixel_y,
                                     rsp_data.last_pixel));
         end else begin
            wanted = pending_pixels.pop_front();
            results_checked++;
            if (rsp_data.last_pixel) line_ends++;
            if (rsp_data.pixel_valid !== wanted.pixel_valid || rsp_data.pixel_x !== wanted.pixel_x
                || rsp_data.pixel_y !== wanted.pixel_y
                || rsp_data.last_pixel !== wanted.last_pixel) begin
               report_failure($sformatf({"result %0d: expected valid=%0b x=%0d y=%0d last=%0b,",
                                         " got valid=%0b x=%0d y=%0d last=%0b"},
                                        results_checked, wanted.pixel_valid, wanted.pixel_x,
                                        wanted.pixel_y, wanted.last_pixel, rsp_data.pixel_valid,
                                        rsp_data.pixel_x, rsp_data.pixel_y,
                                        rsp_data.last_pixel));
            end
         end
      end
   end

   // Ends the run if neither side sees a transfer for too long.
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("Timeout after %0d cycles without a transfer", quiet_cycles);
         $display("Verification failed");
         $finish;
      end
   end

   initial begin : stimulus
      int random_base;
      int random_done;
      bit hold_issued;
      bit drain_issued;
      hold_issued = 1'b0;
      drain_issued = 1'b0;
      pos_x_q = '0;
      pos_y_q = '0;
      step_x_q = '0;
      step_y_q = '0;
      target_x_q = '0;
      target_y_q = '0;
      line_busy = 1'b0;

      directed_rows.push_back(table_row(REQ_NEXT, 0, 0, 0, 0, 1, 0, 0, 0, 0));
      directed_rows.push_back(table_row(REQ_START, 0, 0, 0, 0, 1, 0, 0, 0, 0));
      directed_rows.push_back(table_row(REQ_NEXT, 2047, 2047, 2047, 2047, 1, 0, 0, 0, 0));
      directed_rows.push_back(table_row(REQ_START, 2047, 2047, 2047, 2047, 1, 0, 0, 0, 0));
      directed_rows.push_back(table_row(REQ_NEXT, 0, 0, 0, 0, 1, 0, 0, 0, 0));
      // Horizontal line: three pixels, end point not drawn, then an empty result.
      directed_rows.push_back(table_row(REQ_START, 5, 5, 8, 5, 1, 0, 0, 0, 0));
      directed_rows.push_back(table_row(REQ_NEXT, 0, 0, 0, 0, 1, 1, 5, 5, 0));
      directed_rows.push_back(table_row(REQ_NEXT, 0, 0, 0, 0, 1, 1, 6, 5, 0));
      directed_rows.push_back(table_row(REQ_NEXT, 0, 0, 0, 0, 1, 1, 7, 5, 1));
      directed_rows.push_back(table_row(REQ_NEXT, 0, 0, 0, 0, 1, 0, 0, 0, 0));
      // Vertical line running down from the top row.
      directed_rows.push_back(table_row(REQ_START, 10, 2047, 10, 2045, 1, 0, 0, 0, 0));
      directed_rows.push_back(table_row(REQ_NEXT, 2047, 0, 2047, 0, 1, 1, 10, 2047, 0));
      directed_rows.push_back(table_row(REQ_NEXT, 0, 0, 0, 0, 1, 1, 10, 2046, 1));
      // Full diagonal, abandoned by a new start while it is still being drawn.
      directed_rows.push_back(table_row(REQ_START, 0, 0, 2047, 2047, 1, 0, 0, 0, 0));
      directed_rows.push_back(table_row(REQ_NEXT, 0, 0, 0, 0, 1, 1, 0, 0, 0));
      directed_rows.push_back(table_row(REQ_NEXT, 0, 0, 0, 0, 1, 1, 1, 1, 0));
      directed_rows.push_back(table_row(REQ_START, 2047, 0, 0, 3, 1, 0, 0, 0, 0));
      directed_rows.push_back(table_row(REQ_NEXT, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      directed_rows.push_back(table_row(REQ_NEXT, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      // Steep line with a fractional minor step.
      directed_rows.push_back(table_row(REQ_START, 1, 2000, 4, 2047, 1, 0, 0, 0, 0));
      directed_rows.push_back(table_row(REQ_NEXT, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      directed_rows.push_back(table_row(REQ_NEXT, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      directed_rows.push_back(table_row(REQ_NEXT, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      directed_rows.push_back(table_row(REQ_START, 0, 2047, 2047, 0, 1, 0, 0, 0, 0));
      directed_rows.push_back(table_row(REQ_NEXT, 0, 0, 0, 0, 1, 1, 0, 2047, 0));

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         send_request(directed_rows[i].request, directed_rows[i].typed, directed_rows[i].pixel);
      end
      req_push <= 1'b0;
      wait_for_drain();

      random_base = drawing_requests;
      random_done = 0;
      while (random_done < RANDOM_ITEMS) begin
         if (!hold_issued && random_done >= 250) begin
            hold_off_request = 1'b1;
            hold_issued = 1'b1;
         end
         steady_stretch = (random_done >= 450) && (random_done < 700);
         if (!drain_issued && random_done >= 850) begin
            req_push <= 1'b0;
            wait_for_drain();
            drain_issued = 1'b1;
         end
         run_line_sequence();
         random_done = drawing_requests - random_base;
      end
      req_push <= 1'b0;
      steady_stretch = 1'b0;

      wait_for_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d line starts and %0d pixel requests; %0d results checked, %0d line ends.",
               lines_started, pixel_requests, results_checked, line_ends);
      $display("Included a %0d-cycle output hold-off against a full input and a drain pause.",
               HOLD_OFF_CYCLES);
      if (failure_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("%0d failures in total", failure_count);
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/dda_pkg.sv
hw/rtl/dda_front.sv
hw/rtl/dda_queue.sv
hw/rtl/dda_back.sv
hw/rtl/dda_line_rasterizer.sv
tb/sv/tb_dda_line_rasterizer.sv
